// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for pressure compensation
// Fixed calibration points, field widths and register indexes.
// ----------------------------------------------------------------------------
package bpc_pkg;

   // Field widths
   localparam int PRES_W = 24;
   localparam int TEMP_W = 16;
   localparam int OUT_W  = 18;
   localparam int COEF_W = 16;

   // Intermediate widths (unsigned lookup points, two's complement otherwise)
   localparam int TT_W  = 31;
   localparam int S0_W  = 31;
   localparam int S1_W  = 36;
   localparam int S2_W  = 33;
   localparam int CN_W  = 74;
   localparam int CD_W  = 42;
   localparam int AN_W  = 91;
   localparam int AD_W  = 37;
   localparam int A8_W  = 99;
   localparam int K_W   = 100;
   localparam int QD_W  = 75;
   localparam int W_W   = 128;

   // Lower and upper lookup point bases in Q8
   localparam logic [S0_W-1:0] S0_BASE  = 31'd939524096;
   localparam logic [S2_W-1:0] S2_BASE  = 33'd3087007744;
   // Lowest calibration pressure in Q8
   localparam logic [K_W-1:0]  P0_Q8    = 100'd11520000;
   localparam logic [OUT_W-1:0] OUT_MAX = 18'h3FFFF;
   localparam logic [TEMP_W:0] T_CENTER = 17'd32768;

   // Register indexes
   localparam logic [1:0] REG_COEFF0 = 2'd0;
   localparam logic [1:0] REG_COEFF1 = 2'd1;
   localparam logic [1:0] REG_COEFF2 = 2'd2;
   localparam logic [1:0] REG_COEFF3 = 2'd3;

   typedef logic [3:0][COEF_W-1:0] coeff_set_type;

endpackage

// ===== rtl/bpc_sdiv.sv =====
// ----------------------------------------------------------------------------
// bpc_sdiv: pipelined signed divider
// Restoring division, one quotient bit per stage, truncated toward zero.
// A zero divisor gives a zero quotient. Side data travels with each word.
// ----------------------------------------------------------------------------
module bpc_sdiv #(
   parameter int NW = 8,
   parameter int DW = 8,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] side_in,
   output logic          out_valid,
   output logic [NW-1:0] quo,
   output logic [SW-1:0] side_out
);

   logic          v_ff    [NW+1];
   logic [DW-1:0] rem_ff  [NW+1];
   logic [NW-1:0] qn_ff   [NW+1];
   logic [DW-1:0] d_ff    [NW+1];
   logic          neg_ff  [NW+1];
   logic          dz_ff   [NW+1];
   logic [SW-1:0] sd_ff   [NW+1];
   logic          vout_ff;
   logic [NW-1:0] quo_ff;
   logic [SW-1:0] sout_ff;

   // Entry: magnitudes and sign
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         qn_ff[0]  <= num[NW-1] ? -num : num;
         d_ff[0]   <= den[DW-1] ? -den : den;
         neg_ff[0] <= num[NW-1] ^ den[DW-1];
         dz_ff[0]  <= (den == '0);
         sd_ff[0]  <= side_in;
      end
   end

   // One quotient bit per stage
   for (genvar k = 0; k < NW; k++) begin : g_step
      logic [DW:0]   tmp;
      logic [DW:0]   sub;
      logic          ge;
      logic [DW-1:0] rem_in;

      always_comb begin
         tmp    = {rem_ff[k], qn_ff[k][NW-1]};
         sub    = tmp - {1'b0, d_ff[k]};
         ge     = (tmp >= {1'b0, d_ff[k]});
         rem_in = ge ? sub[DW-1:0] : tmp[DW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            qn_ff[k+1]  <= {qn_ff[k][NW-2:0], ge};
            d_ff[k+1]   <= d_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            dz_ff[k+1]  <= dz_ff[k];
            sd_ff[k+1]  <= sd_ff[k];
         end
      end
   end

   // Exit: apply sign, zero divisor case
   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (en) begin
         vout_ff <= v_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (dz_ff[NW]) begin
            quo_ff <= '0;
         end else if (neg_ff[NW]) begin
            quo_ff <= -qn_ff[NW];
         end else begin
            quo_ff <= qn_ff[NW];
         end
         sout_ff <= sd_ff[NW];
      end
   end

   assign out_valid = vout_ff;
   assign quo       = quo_ff;
   assign side_out  = sout_ff;

endmodule

// ===== rtl/bpc_mul.sv =====
// ----------------------------------------------------------------------------
// bpc_mul: pipelined 128-bit wrapping multiplier
// 32-bit limbs, ten partial products, column sums, final add.
// ----------------------------------------------------------------------------
module bpc_mul #(
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [127:0]  a,
   input  logic [127:0]  b,
   input  logic [SW-1:0] side_in,
   output logic          out_valid,
   output logic [127:0]  prod,
   output logic [SW-1:0] side_out
);

   logic [63:0]  pp_ff [10];
   logic [64:0]  col1_ff;
   logic [65:0]  col2_ff;
   logic [65:0]  col3_ff;
   logic [63:0]  col0_ff;
   logic [127:0] prod_ff;
   logic         v_ff [3];
   logic [SW-1:0] sd_ff [3];

   // Valid travels with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
         v_ff[1] <= 1'b0;
         v_ff[2] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
      end
   end

   // Partial products below 2^128
   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff[0] <= a[31:0]   * b[31:0];
         pp_ff[1] <= a[31:0]   * b[63:32];
         pp_ff[2] <= a[63:32]  * b[31:0];
         pp_ff[3] <= a[31:0]   * b[95:64];
         pp_ff[4] <= a[63:32]  * b[63:32];
         pp_ff[5] <= a[95:64]  * b[31:0];
         pp_ff[6] <= a[31:0]   * b[127:96];
         pp_ff[7] <= a[63:32]  * b[95:64];
         pp_ff[8] <= a[95:64]  * b[63:32];
         pp_ff[9] <= a[127:96] * b[31:0];
         sd_ff[0] <= side_in;
      end
   end

   // Column sums by limb weight
   always_ff @(posedge clock) begin
      if (en) begin
         col0_ff  <= pp_ff[0];
         col1_ff  <= {1'b0, pp_ff[1]} + {1'b0, pp_ff[2]};
         col2_ff  <= {2'b0, pp_ff[3]} + {2'b0, pp_ff[4]} + {2'b0, pp_ff[5]};
         col3_ff  <= {2'b0, pp_ff[6]} + {2'b0, pp_ff[7]} + {2'b0, pp_ff[8]}
                     + {2'b0, pp_ff[9]};
         sd_ff[1] <= sd_ff[0];
      end
   end

   // Final sum, wraps at 128 bits
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= {64'b0, col0_ff} + {31'b0, col1_ff, 32'b0}
                     + {col2_ff[63:0], 64'b0} + {col3_ff[31:0], 96'b0};
         sd_ff[2] <= sd_ff[1];
      end
   end

   assign out_valid = v_ff[2];
   assign prod      = prod_ff;
   assign side_out  = sd_ff[2];

endmodule

// ===== rtl/bpc_front.sv =====
// ----------------------------------------------------------------------------
// bpc_front: lookup points and pole equation terms
// Centred temperature squared, three lookup points, then the numerator and
// denominator of the pole C. Five register stages.
// ----------------------------------------------------------------------------
module bpc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [bpc_pkg::PRES_W-1:0]     raw_pressure,
   input  logic [bpc_pkg::TEMP_W-1:0]     raw_temperature,
   input  bpc_pkg::coeff_set_type         coeff,
   output logic                           out_valid,
   output logic [bpc_pkg::CN_W-1:0]       cnum,
   output logic [bpc_pkg::CD_W-1:0]       cden,
   output logic [bpc_pkg::S0_W-1:0]       s0,
   output logic [bpc_pkg::S1_W-1:0]       s1,
   output logic [bpc_pkg::PRES_W-1:0]     pres
);

   import bpc_pkg::*;

   logic              v_ff [5];
   logic [PRES_W-1:0] p_ff [5];
   logic [TEMP_W:0]   t_in;
   logic [2*TEMP_W+1:0] tsq_in;
   logic [TT_W-1:0]   tt_ff;
   logic [46:0]       m0_ff, m1_ff, m2_ff;
   logic [S0_W-1:0]   s0_ff, s0b_ff, s0c_ff;
   logic [S1_W-1:0]   s1_ff, s1b_ff, s1c_ff;
   logic [S2_W-1:0]   s2_ff;
   logic [63:0]       p20_ff;
   logic [66:0]       p01_ff;
   logic [68:0]       p12_ff;
   logic [CD_W-1:0]   cden_ff, cdenb_ff;
   logic [CN_W-1:0]   cnum_ff;

   // Valid and pressure pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < 5; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= raw_pressure;
         for (int i = 1; i < 5; i++) begin
            p_ff[i] <= p_ff[i-1];
         end
      end
   end

   // Centred temperature, squared (two's complement square, low bits exact)
   always_comb begin
      t_in   = {1'b0, raw_temperature} - T_CENTER;
      tsq_in = $signed(t_in) * $signed(t_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tt_ff <= tsq_in[TT_W-1:0];
      end
   end

   // Coefficient times t squared
   always_ff @(posedge clock) begin
      if (en) begin
         m0_ff <= coeff[0] * tt_ff;
         m1_ff <= coeff[1] * tt_ff;
         m2_ff <= coeff[2] * tt_ff;
      end
   end

   // Lookup points in Q8
   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= S0_BASE + m0_ff[46:16];
         s1_ff <= {1'b0, coeff[3], 19'b0} + {5'b0, m1_ff[46:16]};
         s2_ff <= S2_BASE + {2'b0, m2_ff[46:16]};
      end
   end

   // Pair products and pole denominator
   always_ff @(posedge clock) begin
      if (en) begin
         p20_ff  <= s2_ff * s0_ff;
         p01_ff  <= s0_ff * s1_ff;
         p12_ff  <= s1_ff * s2_ff;
         cden_ff <= 42'd12 * {6'b0, s1_ff} - 42'd7 * {9'b0, s2_ff}
                    - 42'd5 * {11'b0, s0_ff};
         s0b_ff  <= s0_ff;
         s1b_ff  <= s1_ff;
      end
   end

   // Pole numerator
   always_ff @(posedge clock) begin
      if (en) begin
         cnum_ff  <= 74'd12 * {10'b0, p20_ff} - 74'd7 * {7'b0, p01_ff}
                     - 74'd5 * {5'b0, p12_ff};
         cdenb_ff <= cden_ff;
         s0c_ff   <= s0b_ff;
         s1c_ff   <= s1b_ff;
      end
   end

   assign out_valid = v_ff[4];
   assign cnum      = cnum_ff;
   assign cden      = cdenb_ff;
   assign s0        = s0c_ff;
   assign s1        = s1c_ff;
   assign pres      = p_ff[4];

endmodule

// ===== rtl/barometric_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// barometric_pressure_compensation: three-point rational pressure fit
// Raw pressure and temperature in, compensated pressure in pascals out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | raw_pressure, raw_temperature
//  rsp     | out       | rsp_valid/rsp_stall | pressure_pa
//  csr     | in        | APB write/read      | otp_coeff_0..3 at 0x0..0xC
//
//  One word per cycle sustained while rsp_stall does not hold the pipe; the
//  three bit-per-stage dividers have 76, 101 and 130 stages.
//  The whole pipe moves together; it freezes only while a result is held
//  at the output under rsp_stall.
//  Synchronous reset clears the valid bits and the factory words.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [23:0]  req_raw_pressure,
   input  logic [15:0]  req_raw_temperature,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [17:0]  rsp_pressure_pa,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   import bpc_pkg::*;

   coeff_set_type     coeff_ff;
   logic              en;

   logic              f_v;
   logic [CN_W-1:0]   f_cnum;
   logic [CD_W-1:0]   f_cden;
   logic [S0_W-1:0]   f_s0;
   logic [S1_W-1:0]   f_s1;
   logic [PRES_W-1:0] f_p;

   logic              d1_v;
   logic [CN_W-1:0]   d1_c8;
   logic [S0_W+S1_W+PRES_W-1:0] d1_side;
   logic [S0_W-1:0]   d1_s0;
   logic [S1_W-1:0]   d1_s1;
   logic [PRES_W-1:0] d1_p;

   logic              g1_v_ff;
   logic [AN_W-1:0]   an_ff;
   logic [AD_W-1:0]   ad_ff;
   logic [S0_W-1:0]   g1_s0_ff;
   logic [CN_W-1:0]   g1_c8_ff;
   logic [PRES_W-1:0] g1_p_ff;

   logic              d2_v;
   logic [A8_W-1:0]   d2_a8;
   logic [S0_W+CN_W+PRES_W-1:0] d2_side;
   logic [S0_W-1:0]   d2_s0;
   logic [CN_W-1:0]   d2_c8;
   logic [PRES_W-1:0] d2_p;

   logic              g2_v_ff;
   logic [K_W-1:0]    k_ff;
   logic [QD_W-1:0]   sc_ff;
   logic [QD_W-1:0]   qd_ff;
   logic [A8_W-1:0]   g2_a8_ff;

   logic              m_v;
   logic [W_W-1:0]    m_b16;
   logic [QD_W+A8_W-1:0] m_side;

   logic              d3_v;
   logic [W_W-1:0]    d3_q;
   logic [A8_W-1:0]   d3_a8;

   logic              g3_v_ff;
   logic [W_W-1:0]    r_ff;

   logic              out_v_ff;
   logic [OUT_W-1:0]  out_p_ff;
   logic [OUT_W-1:0]  sat_in;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         coeff_ff[csr_paddr[3:2]] <= csr_pwdata[COEF_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_COEFF0: csr_prdata = {16'b0, coeff_ff[0]};
         REG_COEFF1: csr_prdata = {16'b0, coeff_ff[1]};
         REG_COEFF2: csr_prdata = {16'b0, coeff_ff[2]};
         REG_COEFF3: csr_prdata = {16'b0, coeff_ff[3]};
         default:    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // Pipe advance: hold only while the output word waits
   assign en        = !(out_v_ff && rsp_stall);
   assign req_stall = !en;

   bpc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (req_valid),
      .raw_pressure    (req_raw_pressure),
      .raw_temperature (req_raw_temperature),
      .coeff           (coeff_ff),
      .out_valid       (f_v),
      .cnum            (f_cnum),
      .cden            (f_cden),
      .s0              (f_s0),
      .s1              (f_s1),
      .pres            (f_p)
   );

   // Pole C8 = cnum / cden
   bpc_sdiv #(.NW(CN_W), .DW(CD_W), .SW(S0_W+S1_W+PRES_W)) u_div_c (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_v),
      .num       (f_cnum),
      .den       (f_cden),
      .side_in   ({f_s0, f_s1, f_p}),
      .out_valid (d1_v),
      .quo       (d1_c8),
      .side_out  (d1_side)
   );

   assign {d1_s0, d1_s1, d1_p} = d1_side;

   // Offset numerator and denominator
   always_ff @(posedge clock) begin
      if (reset) begin
         g1_v_ff <= 1'b0;
      end else if (en) begin
         g1_v_ff <= d1_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         an_ff    <= 91'd45000 * {60'b0, d1_s0} - 91'd80000 * {55'b0, d1_s1}
                     - 91'd35000 * {{17{d1_c8[CN_W-1]}}, d1_c8};
         ad_ff    <= {6'b0, d1_s0} - {1'b0, d1_s1};
         g1_s0_ff <= d1_s0;
         g1_c8_ff <= d1_c8;
         g1_p_ff  <= d1_p;
      end
   end

   // Offset A8
   bpc_sdiv #(.NW(A8_W), .DW(AD_W), .SW(S0_W+CN_W+PRES_W)) u_div_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g1_v_ff),
      .num       ({an_ff, 8'b0}),
      .den       (ad_ff),
      .side_in   ({g1_s0_ff, g1_c8_ff, g1_p_ff}),
      .out_valid (d2_v),
      .quo       (d2_a8),
      .side_out  (d2_side)
   );

   assign {d2_s0, d2_c8, d2_p} = d2_side;

   // Scale factor operands and final divisor
   always_ff @(posedge clock) begin
      if (reset) begin
         g2_v_ff <= 1'b0;
      end else if (en) begin
         g2_v_ff <= d2_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_ff     <= P0_Q8 - {d2_a8[A8_W-1], d2_a8};
         sc_ff    <= {44'b0, d2_s0} + {d2_c8[CN_W-1], d2_c8};
         qd_ff    <= {d2_c8[CN_W-1], d2_c8} + {43'b0, d2_p, 8'b0};
         g2_a8_ff <= d2_a8;
      end
   end

   // B16 = (P0 - A8) * (s0 + C8)
   bpc_mul #(.SW(QD_W+A8_W)) u_mul_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g2_v_ff),
      .a         ({{28{k_ff[K_W-1]}}, k_ff}),
      .b         ({{53{sc_ff[QD_W-1]}}, sc_ff}),
      .side_in   ({qd_ff, g2_a8_ff}),
      .out_valid (m_v),
      .prod      (m_b16),
      .side_out  (m_side)
   );

   // B16 / (C8 + x)
   bpc_sdiv #(.NW(W_W), .DW(QD_W), .SW(A8_W)) u_div_q (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_v),
      .num       (m_b16),
      .den       (m_side[QD_W+A8_W-1:A8_W]),
      .side_in   (m_side[A8_W-1:0]),
      .out_valid (d3_v),
      .quo       (d3_q),
      .side_out  (d3_a8)
   );

   // R8 = A8 + quotient
   always_ff @(posedge clock) begin
      if (reset) begin
         g3_v_ff <= 1'b0;
      end else if (en) begin
         g3_v_ff <= d3_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= {{29{d3_a8[A8_W-1]}}, d3_a8} + d3_q;
      end
   end

   // Truncate Q8 and saturate
   always_comb begin
      priority if (r_ff[W_W-1]) begin
         sat_in = '0;
      end else if (r_ff[W_W-2:26] != '0) begin
         sat_in = OUT_MAX;
      end else begin
         sat_in = r_ff[25:8];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= g3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_p_ff <= sat_in;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_pressure_pa = out_p_ff;

endmodule
